// ===== design/assert_macros.svh =====
// Assertion helpers for the priority table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/ipt_pkg.sv =====
`timescale 1ns / 1ps

package ipt_pkg;

  localparam int CAPACITY       = 64;
  localparam int VALUE_WIDTH    = 32;
  localparam int PRIORITY_WIDTH = 16;

  localparam int ID_W    = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int ENTRY_W = VALUE_WIDTH + PRIORITY_WIDTH;

  // Fixed field widths on the ports.
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int RID_W    = 6;
  localparam int RVAL_W   = 32;
  localparam int RPRIO_W  = 16;

  localparam logic [PRIORITY_WIDTH-1:0] PRIO_MAX = '1;

  localparam logic [KIND_W-1:0] KIND_ADD     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PROMOTE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_GET_MAX = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_MAX = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LOOKUP  = 3'd4;

  localparam logic [STATUS_W-1:0] STS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STS_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STS_BAD_ID = 2'd2;
  localparam logic [STATUS_W-1:0] STS_EMPTY  = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic            en;
    logic [ID_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] limit;
  } scan_ctl_t;

  typedef struct packed {
    logic                      done;
    logic                      found;
    logic [ID_W-1:0]           best_id;
    logic [VALUE_WIDTH-1:0]    best_val;
    logic [PRIORITY_WIDTH-1:0] best_prio;
  } scan_sts_t;

endpackage

// ===== design/indexed_max_priority_table_top.sv =====
`timescale 1ns / 1ps

// Indexed max-priority table: one transaction in, one result out. Add and unused
// kinds go straight to the emit state; promote and lookup of a live id read their
// entry first. Get_max and pop_max scan every id issued so far (at most 64), since
// the scan reads one entry per cycle from the single entry memory. A stalled result
// port holds the finished result in the emit state. Live bits are flip-flops cleared
// by reset, so the table is usable right after reset.
// A finished result sits in the output register while the next transaction is
// taken; its side effects are applied when the result moves into that register.

`include "assert_macros.svh"

module indexed_max_priority_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // object_value[31:0], item_id[37:32], zero pad
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // result_id[5:0], result_value[37:6],
                                  // result_priority[53:38], is_live[54], zero pad
  output logic [1:0]  out_tuser   // status[1:0]
);

  ipt_pkg::state_t                     state_r, state_nxt;
  logic [ipt_pkg::KIND_W-1:0]          kind_r, kind_nxt;
  logic [ipt_pkg::VALUE_WIDTH-1:0]     val_r, val_nxt;
  logic [ipt_pkg::CAPACITY-1:0]        live_r, live_nxt;
  logic [ipt_pkg::CNT_W-1:0]           nfree_r, nfree_nxt;

  logic [ipt_pkg::STATUS_W-1:0]        p_status_r, p_status_nxt;
  logic [ipt_pkg::ID_W-1:0]            p_id_r, p_id_nxt;
  logic [ipt_pkg::VALUE_WIDTH-1:0]     p_val_r, p_val_nxt;
  logic [ipt_pkg::PRIORITY_WIDTH-1:0]  p_prio_r, p_prio_nxt;
  logic                                p_live_r, p_live_nxt;

  logic                                out_valid_r, out_valid_nxt;
  logic [ipt_pkg::STATUS_W-1:0]        o_status_r, o_status_nxt;
  logic [ipt_pkg::RID_W-1:0]           o_id_r, o_id_nxt;
  logic [ipt_pkg::RVAL_W-1:0]          o_val_r, o_val_nxt;
  logic [ipt_pkg::RPRIO_W-1:0]         o_prio_r, o_prio_nxt;
  logic                                o_live_r, o_live_nxt;

  logic [ipt_pkg::KIND_W-1:0]          in_kind;
  logic [ipt_pkg::VALUE_WIDTH-1:0]     in_val;
  logic [ipt_pkg::RID_W-1:0]           in_id_raw;
  logic [ipt_pkg::ID_W-1:0]            in_id;
  logic                                in_id_ok;
  logic                                in_fire;
  logic                                out_free;

  logic                                lk_rd_en;
  logic                                wr_en;
  logic [ipt_pkg::ID_W-1:0]            wr_addr;
  logic [ipt_pkg::ENTRY_W-1:0]         wr_data;
  logic [ipt_pkg::ENTRY_W-1:0]         rd_data;
  logic [ipt_pkg::PRIORITY_WIDTH-1:0]  rd_prio;
  logic [ipt_pkg::PRIORITY_WIDTH-1:0]  new_prio;

  ipt_pkg::rd_req_t                    scan_rd;
  ipt_pkg::rd_req_t                    mem_rd;
  ipt_pkg::scan_ctl_t                  scan_ctl;
  ipt_pkg::scan_sts_t                  scan_sts;

  assign in_kind   = in_tuser;
  assign in_val    = ipt_pkg::VALUE_WIDTH'(in_tdata[31:0]);
  assign in_id_raw = in_tdata[37:32];
  assign in_id     = ipt_pkg::ID_W'(in_id_raw);
  assign in_id_ok  = (32'(in_id_raw) < ipt_pkg::CAPACITY) && live_r[in_id];
  assign in_tready = (state_r == ipt_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign lk_rd_en = in_fire && in_id_ok &&
                    (in_kind == ipt_pkg::KIND_PROMOTE || in_kind == ipt_pkg::KIND_LOOKUP);
  assign mem_rd.en   = lk_rd_en || scan_rd.en;
  assign mem_rd.addr = lk_rd_en ? in_id : scan_rd.addr;

  assign rd_prio  = rd_data[ipt_pkg::PRIORITY_WIDTH-1:0];
  assign new_prio = (kind_r == ipt_pkg::KIND_PROMOTE && rd_prio != ipt_pkg::PRIO_MAX) ?
                    rd_prio + 1'b1 : rd_prio;

  assign scan_ctl.start = in_fire &&
                          (in_kind == ipt_pkg::KIND_GET_MAX || in_kind == ipt_pkg::KIND_POP_MAX);
  assign scan_ctl.limit = nfree_r;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    val_nxt       = val_r;
    live_nxt      = live_r;
    nfree_nxt     = nfree_r;
    p_status_nxt  = p_status_r;
    p_id_nxt      = p_id_r;
    p_val_nxt     = p_val_r;
    p_prio_nxt    = p_prio_r;
    p_live_nxt    = p_live_r;
    out_valid_nxt = out_valid_r && !out_tready;
    o_status_nxt  = o_status_r;
    o_id_nxt      = o_id_r;
    o_val_nxt     = o_val_r;
    o_prio_nxt    = o_prio_r;
    o_live_nxt    = o_live_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;

    case (state_r)
      ipt_pkg::S_IDLE: begin
        if (in_fire) begin
          kind_nxt     = in_kind;
          val_nxt      = in_val;
          p_status_nxt = ipt_pkg::STS_OK;
          p_id_nxt     = '0;
          p_val_nxt    = '0;
          p_prio_nxt   = '0;
          p_live_nxt   = 1'b0;
          state_nxt    = ipt_pkg::S_EMIT;
          case (in_kind)
            ipt_pkg::KIND_ADD: begin
              if (32'(nfree_r) >= ipt_pkg::CAPACITY) begin
                p_status_nxt = ipt_pkg::STS_FULL;
              end else begin
                p_id_nxt   = nfree_r[ipt_pkg::ID_W-1:0];
                p_live_nxt = 1'b1;
              end
            end
            ipt_pkg::KIND_PROMOTE, ipt_pkg::KIND_LOOKUP: begin
              p_id_nxt = in_id;
              if (in_id_ok) begin
                state_nxt = ipt_pkg::S_LOOK;
              end else begin
                p_status_nxt = ipt_pkg::STS_BAD_ID;
              end
            end
            ipt_pkg::KIND_GET_MAX, ipt_pkg::KIND_POP_MAX: begin
              state_nxt = ipt_pkg::S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ipt_pkg::S_LOOK: begin
        p_val_nxt  = rd_data[ipt_pkg::ENTRY_W-1:ipt_pkg::PRIORITY_WIDTH];
        p_prio_nxt = new_prio;
        p_live_nxt = 1'b1;
        state_nxt  = ipt_pkg::S_EMIT;
      end
      ipt_pkg::S_SCAN: begin
        if (scan_sts.done) begin
          if (scan_sts.found) begin
            p_id_nxt   = scan_sts.best_id;
            p_val_nxt  = scan_sts.best_val;
            p_prio_nxt = scan_sts.best_prio;
            p_live_nxt = (kind_r == ipt_pkg::KIND_GET_MAX);
          end else begin
            p_status_nxt = ipt_pkg::STS_EMPTY;
          end
          state_nxt = ipt_pkg::S_EMIT;
        end
      end
      ipt_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = p_status_r;
          o_id_nxt      = ipt_pkg::RID_W'(p_id_r);
          o_val_nxt     = ipt_pkg::RVAL_W'(p_val_r);
          o_prio_nxt    = ipt_pkg::RPRIO_W'(p_prio_r);
          o_live_nxt    = p_live_r;
          state_nxt     = ipt_pkg::S_IDLE;
          if (p_status_r == ipt_pkg::STS_OK) begin
            case (kind_r)
              ipt_pkg::KIND_ADD: begin
                wr_en             = 1'b1;
                wr_addr           = p_id_r;
                wr_data           = {val_r, {ipt_pkg::PRIORITY_WIDTH{1'b0}}};
                live_nxt[p_id_r]  = 1'b1;
                nfree_nxt         = nfree_r + 1'b1;
              end
              ipt_pkg::KIND_PROMOTE: begin
                wr_en   = 1'b1;
                wr_addr = p_id_r;
                wr_data = {p_val_r, p_prio_r};
              end
              ipt_pkg::KIND_POP_MAX: begin
                live_nxt[p_id_r] = 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
      end
      default: begin
        state_nxt = ipt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ipt_pkg::S_IDLE;
      live_r      <= '0;
      nfree_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      nfree_r     <= nfree_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    val_r      <= val_nxt;
    p_status_r <= p_status_nxt;
    p_id_r     <= p_id_nxt;
    p_val_r    <= p_val_nxt;
    p_prio_r   <= p_prio_nxt;
    p_live_r   <= p_live_nxt;
    o_status_r <= o_status_nxt;
    o_id_r     <= o_id_nxt;
    o_val_r    <= o_val_nxt;
    o_prio_r   <= o_prio_nxt;
    o_live_r   <= o_live_nxt;
  end

  ipt_ram #(
    .WIDTH (ipt_pkg::ENTRY_W),
    .DEPTH (ipt_pkg::CAPACITY)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (mem_rd.en),
    .rd_addr (mem_rd.addr),
    .rd_data (rd_data)
  );

  ipt_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (scan_ctl),
    .live    (live_r),
    .rd_data (rd_data),
    .rd      (scan_rd),
    .sts     (scan_sts)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_status_r;
  assign out_tdata  = {1'b0, o_live_r, o_prio_r, o_val_r, o_id_r};

  `ASSERT_IMPLIES(a_nfree_bound, clk, rst_n, 1'b1, 32'(nfree_r) <= ipt_pkg::CAPACITY)
  `ASSERT_IMPLIES(a_live_issued, clk, rst_n, 1'b1, (live_r >> nfree_r) == '0)
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, in_fire, state_r != ipt_pkg::S_IDLE)
  `ASSERT_NEXT(a_emit_loads, clk, rst_n, state_r == ipt_pkg::S_EMIT && out_free, out_valid_r)

endmodule

// ===== design/ipt_ram.sv =====
`timescale 1ns / 1ps

module ipt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/ipt_scan.sv =====
`timescale 1ns / 1ps

module ipt_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ipt_pkg::scan_ctl_t            ctl,
  input  logic [ipt_pkg::CAPACITY-1:0]  live,
  input  logic [ipt_pkg::ENTRY_W-1:0]   rd_data,
  output ipt_pkg::rd_req_t              rd,
  output ipt_pkg::scan_sts_t            sts
);

  logic                                  busy_r, busy_nxt;
  logic [ipt_pkg::CNT_W-1:0]             idx_r, idx_nxt;
  logic                                  pipe_vld_r, pipe_vld_nxt;
  logic [ipt_pkg::ID_W-1:0]              pipe_id_r, pipe_id_nxt;
  logic                                  done_r, done_nxt;
  logic                                  found_r, found_nxt;
  logic [ipt_pkg::ID_W-1:0]              best_id_r, best_id_nxt;
  logic [ipt_pkg::VALUE_WIDTH-1:0]       best_val_r, best_val_nxt;
  logic [ipt_pkg::PRIORITY_WIDTH-1:0]    best_prio_r, best_prio_nxt;
  logic [ipt_pkg::PRIORITY_WIDTH-1:0]    rd_prio;
  logic [ipt_pkg::VALUE_WIDTH-1:0]       rd_val;

  assign rd_prio = rd_data[ipt_pkg::PRIORITY_WIDTH-1:0];
  assign rd_val  = rd_data[ipt_pkg::ENTRY_W-1:ipt_pkg::PRIORITY_WIDTH];

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    pipe_vld_nxt  = pipe_vld_r;
    pipe_id_nxt   = pipe_id_r;
    done_nxt      = 1'b0;
    found_nxt     = found_r;
    best_id_nxt   = best_id_r;
    best_val_nxt  = best_val_r;
    best_prio_nxt = best_prio_r;
    rd            = '0;
    if (ctl.start) begin
      busy_nxt     = 1'b1;
      idx_nxt      = '0;
      pipe_vld_nxt = 1'b0;
      found_nxt    = 1'b0;
    end else if (busy_r) begin
      // ties go to the later id
      if (pipe_vld_r && live[pipe_id_r] && (!found_r || rd_prio >= best_prio_r)) begin
        found_nxt     = 1'b1;
        best_id_nxt   = pipe_id_r;
        best_val_nxt  = rd_val;
        best_prio_nxt = rd_prio;
      end
      if (idx_r < ctl.limit) begin
        rd.en        = 1'b1;
        rd.addr      = idx_r[ipt_pkg::ID_W-1:0];
        idx_nxt      = idx_r + 1'b1;
        pipe_vld_nxt = 1'b1;
        pipe_id_nxt  = idx_r[ipt_pkg::ID_W-1:0];
      end else begin
        pipe_vld_nxt = 1'b0;
        if (!pipe_vld_r) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      pipe_vld_r <= 1'b0;
      done_r     <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      pipe_vld_r <= pipe_vld_nxt;
      done_r     <= done_nxt;
      found_r    <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pipe_id_r   <= pipe_id_nxt;
    best_id_r   <= best_id_nxt;
    best_val_r  <= best_val_nxt;
    best_prio_r <= best_prio_nxt;
  end

  assign sts.done      = done_r;
  assign sts.found     = found_r;
  assign sts.best_id   = best_id_r;
  assign sts.best_val  = best_val_r;
  assign sts.best_prio = best_prio_r;

endmodule
